// ===== src/ucle_pkg.sv =====
// ----------------------------------------------------------------------------
// ucle_pkg: shared types and constants of the UART capture line encoder
// Holds the fixed text fragments, base64 alphabet, status and segment codes.
// ----------------------------------------------------------------------------
`default_nettype none
package ucle_pkg;

   // status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_OVF   = 2'd1;
   localparam logic [1:0] STATUS_NOSPC = 2'd2;

   // fixed text lengths
   localparam int HEAD_LEN = 25;
   localparam int TS_LEN   = 16;
   localparam int DATA_LEN = 13;
   localparam int TAIL_LEN = 3;
   localparam int FIXED_LEN = HEAD_LEN + TS_LEN + DATA_LEN + TAIL_LEN;

   // segment codes for the character sequencer
   localparam logic [2:0] SEG_HEAD = 3'd0;
   localparam logic [2:0] SEG_CH   = 3'd1;
   localparam logic [2:0] SEG_TS   = 3'd2;
   localparam logic [2:0] SEG_TS_D = 3'd3;
   localparam logic [2:0] SEG_DATA = 3'd4;
   localparam logic [2:0] SEG_B64  = 3'd5;
   localparam logic [2:0] SEG_TAIL = 3'd6;
   localparam logic [2:0] SEG_DONE = 3'd7;

   // result word handed from core to output stage
   typedef struct packed {
      logic [63:0] text_chars;
      logic [3:0]  char_count;
      logic [1:0]  status;
      logic [8:0]  line_length;
      logic        last_word;
   } word_type;

   function automatic logic [7:0] head_char(input logic [4:0] i);
      logic [8*HEAD_LEN-1:0] s;
      s = "{\"type\":\"uart\",\"channel\":";
      return s[8*(HEAD_LEN-1-i) +: 8];
   endfunction

   function automatic logic [7:0] ts_char(input logic [4:0] i);
      logic [8*TS_LEN-1:0] s;
      s = {",\"timestamp", "_us\":"};
      return s[8*(TS_LEN-1-i) +: 8];
   endfunction

   function automatic logic [7:0] data_char(input logic [4:0] i);
      logic [8*DATA_LEN-1:0] s;
      s = {",\"data_", "b64\":\""};
      return s[8*(DATA_LEN-1-i) +: 8];
   endfunction

   function automatic logic [7:0] tail_char(input logic [4:0] i);
      logic [8*TAIL_LEN-1:0] s;
      s = "\"}\n";
      return s[8*(TAIL_LEN-1-i) +: 8];
   endfunction

   function automatic logic [7:0] b64_char(input logic [5:0] v);
      logic [7:0] c;
      if (v < 6'd26) c = 8'd65 + {2'b00, v};
      else if (v < 6'd52) c = 8'd71 + {2'b00, v};
      else if (v < 6'd62) c = {2'b00, v} - 8'd4;
      else if (v == 6'd62) c = 8'd43;
      else c = 8'd47;
      return c;
   endfunction

endpackage
`default_nettype wire

// ===== src/ucle_dec_unit.sv =====
// ----------------------------------------------------------------------------
// ucle_dec_unit: iterative decimal digit extractor
// Converts a 64-bit value to 20 BCD digits by shift-and-add-three, one bit per
// cycle, then counts the significant digits; digits read out high first.
// ----------------------------------------------------------------------------
`default_nettype none
module ucle_dec_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] value,
   input  wire logic        pop,
   output logic             busy,
   output logic [4:0]       digit_count,
   output logic [7:0]       top_char
);
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SHIFT = 2'd1;
   localparam logic [1:0] ST_COUNT = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [63:0]      bin_ff, bin_in;
   logic [19:0][3:0] bcd_ff, bcd_in;
   logic [19:0][3:0] adj;
   logic [5:0]       bit_ff, bit_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic [4:0]       sig;

   // add three to every digit of five or more ahead of the shift
   always_comb begin
      for (int k = 0; k < 20; k++)
         adj[k] = (bcd_ff[k] >= 4'd5) ? bcd_ff[k] + 4'd3 : bcd_ff[k];
   end

   // significant digits, at least one so zero reads as "0"
   always_comb begin
      sig = 5'd1;
      for (int k = 1; k < 20; k++)
         if (bcd_ff[k] != 4'd0) sig = 5'(k + 1);
   end

   // sequencer: load, 64 shift steps, digit count
   always_comb begin
      state_in = state_ff;
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      bit_in   = bit_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SHIFT;
               bin_in   = value;
               bcd_in   = '0;
               bit_in   = 6'd0;
               cnt_in   = 5'd0;
            end else if (pop && cnt_ff != 5'd0) begin
               cnt_in = cnt_ff - 5'd1;
            end
         end
         ST_SHIFT: begin
            bcd_in = 80'({adj, bin_ff[63]});
            bin_in = {bin_ff[62:0], 1'b0};
            bit_in = bit_ff + 6'd1;
            if (bit_ff == 6'd63) state_in = ST_COUNT;
         end
         ST_COUNT: begin
            cnt_in   = sig;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= 5'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      bit_ff <= bit_in;
   end

   assign busy        = (state_ff != ST_IDLE);
   assign digit_count = cnt_ff;
   assign top_char    = (cnt_ff == 5'd0) ? 8'd48 : {4'h3, bcd_ff[cnt_ff - 5'd1]};

`ifndef ASSERT_OFF
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset) cnt_ff <= 5'd20)
      else $error("digit count out of range");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("converter did not start");
   a_shift_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT && bit_ff == 6'd63) |=> (state_ff == ST_COUNT))
      else $error("shift sequence did not end");
`endif
endmodule
`default_nettype wire

// ===== src/uart_capture_line_encoder_top.sv =====
// ----------------------------------------------------------------------------
// uart_capture_line_encoder_top: UART event to base64 text line framer
// Collects bytes, then emits the text line as 8-character words.
// ----------------------------------------------------------------------------
// Non-last items are taken at one per cycle while collecting. A last item starts
// a line: four decimal conversions, then one character per cycle while the output
// is free, with base64 bytes loaded one at a time per group; input stalled throughout.
// A too-many-bytes result goes through ST_ERR to the output word register.
// Output word register decouples the rsp stall from the character sequencer.
// Reset (synchronous, active high) clears counters, flags and line_capacity
// to 4095; the byte store holds no reset value.
`default_nettype none
module uart_capture_line_encoder_top #(
   parameter int MAX_DATA_BYTES = 48
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last_byte,
   input  wire logic [7:0]  req_channel,
   input  wire logic [63:0] req_event_time,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [63:0]      rsp_text_chars,
   output logic [3:0]       rsp_char_count,
   output logic [1:0]       rsp_status,
   output logic [8:0]       rsp_line_length,
   output logic             rsp_last_word,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [11:0] csr_line_capacity
);
   import ucle_pkg::*;

   localparam int CW = $clog2(MAX_DATA_BYTES + 1);
   localparam int AW = (MAX_DATA_BYTES > 1) ? $clog2(MAX_DATA_BYTES) : 1;

   localparam logic [3:0] ST_COLLECT = 4'd0;
   localparam logic [3:0] ST_DCH     = 4'd1;
   localparam logic [3:0] ST_DTS     = 4'd2;
   localparam logic [3:0] ST_CHECK   = 4'd3;
   localparam logic [3:0] ST_EMIT    = 4'd4;
   localparam logic [3:0] ST_FLUSH   = 4'd5;
   localparam logic [3:0] ST_ERR     = 4'd6;
   localparam logic [3:0] ST_DCH2    = 4'd7;

   logic [3:0]    state_ff, state_in;
   logic [11:0]   cap_ff;
   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic [7:0]    store_ff [MAX_DATA_BYTES];
   logic [7:0]    rd_ff;
   logic [AW-1:0] rd_addr;
   logic [CW-1:0] n_ff;
   logic [63:0]   ts_ff;
   logic [7:0]    ch_ff;
   logic [4:0]    chn_ff, tsn_ff;
   logic [8:0]    len_ff;
   logic [1:0]    err_ff;

   // character sequencer state
   logic [2:0]    seg_ff, seg_in;
   logic [8:0]    idx_ff, idx_in;   // index within segment
   logic [1:0]    ph_ff, ph_in;     // base64 phase within group
   logic [23:0]   grp_ff, grp_in;
   logic [1:0]    ld_ff, ld_in;     // base64 bytes loaded
   logic [63:0]   acc_ff, acc_in;
   logic [3:0]    accn_ff, accn_in;
   logic [8:0]    pos_ff, pos_in;
   logic [CW-1:0] bi_ff, bi_in;     // next byte to read

   // output register
   word_type      out_ff, out_in;
   logic          ov_ff, ov_in;

   // decimal unit
   logic          d_start, d_busy, d_pop;
   logic [63:0]   d_value;
   logic [4:0]    d_cnt;
   logic [7:0]    d_char;

   ucle_dec_unit u_dec (
      .clock(clock), .reset(reset), .start(d_start), .value(d_value),
      .pop(d_pop), .busy(d_busy), .digit_count(d_cnt), .top_char(d_char)
   );

   logic          accept, out_free;
   logic          put;
   logic [7:0]    ch;
   logic [8:0]    len_calc;
   logic [8:0]    b64len;
   logic [15:0]   third_mul;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_COLLECT);
   assign out_free  = !ov_ff || !rsp_stall;
   assign csr_ready = 1'b1;
   assign rd_addr   = bi_ff[AW-1:0];
   // (n + 2) / 3 as multiply by 171 and shift by 9, exact for n up to 381
   assign third_mul = (16'(n_ff) + 16'd2) * 16'd171;
   assign b64len    = {third_mul[15:9], 2'b00};
   assign len_calc  = 9'(FIXED_LEN) + 9'(chn_ff) + 9'(tsn_ff) + b64len;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) cap_ff <= 12'd4095;
      else if (csr_valid) cap_ff <= csr_line_capacity;
   end

   // byte store: write on collect, registered read for base64
   always_ff @(posedge clock) begin
      if (accept && count_ff < CW'(MAX_DATA_BYTES))
         store_ff[count_ff[AW-1:0]] <= req_data_byte;
      rd_ff <= store_ff[rd_addr];
   end

   // character sequencer: one character per cycle when output is free and no conversion or byte load holds it
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      seg_in   = seg_ff;
      idx_in   = idx_ff;
      ph_in    = ph_ff;
      grp_in   = grp_ff;
      ld_in    = ld_ff;
      acc_in   = acc_ff;
      accn_in  = accn_ff;
      pos_in   = pos_ff;
      bi_in    = bi_ff;
      out_in   = out_ff;
      ov_in    = ov_ff && rsp_stall;
      d_start  = 1'b0;
      d_value  = ts_ff;
      d_pop    = 1'b0;
      put      = 1'b0;
      ch       = 8'd0;
      case (state_ff)
         ST_COLLECT: begin
            if (accept) begin
               if (count_ff < CW'(MAX_DATA_BYTES)) count_in = count_ff + CW'(1);
               else ovf_in = 1'b1;
               if (req_last_byte) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  if (ovf_ff || count_ff >= CW'(MAX_DATA_BYTES)) state_in = ST_ERR;
                  else state_in = ST_DCH;
               end
            end
         end
         ST_DCH: begin
            d_start  = 1'b1;
            d_value  = {56'd0, ch_ff};
            state_in = ST_DCH2;
         end
         ST_DCH2: begin
            if (!d_busy) begin
               d_start  = 1'b1;
               state_in = ST_DTS;
            end
         end
         ST_DTS: begin
            if (!d_busy) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            seg_in  = SEG_HEAD;
            idx_in  = 9'd0;
            ph_in   = 2'd0;
            ld_in   = 2'd0;
            bi_in   = '0;
            acc_in  = 64'd0;
            accn_in = 4'd0;
            pos_in  = 9'd0;
            if (len_calc > 9'(cap_ff) && cap_ff < 12'd512) state_in = ST_ERR;
            else begin
               state_in = ST_EMIT;
               d_start  = 1'b1;
               d_value  = {56'd0, ch_ff};
            end
         end
         ST_EMIT: begin
            if (!d_busy) begin
               case (seg_ff)
                  SEG_HEAD: begin
                     put = 1'b1; ch = head_char(idx_ff[4:0]);
                  end
                  SEG_CH: begin
                     put = 1'b1; ch = d_char; d_pop = out_free;
                  end
                  SEG_TS: begin
                     put = 1'b1; ch = ts_char(idx_ff[4:0]);
                  end
                  SEG_TS_D: begin
                     put = 1'b1; ch = d_char; d_pop = out_free;
                  end
                  SEG_DATA: begin
                     put = 1'b1; ch = data_char(idx_ff[4:0]);
                  end
                  SEG_B64: begin
                     // load three bytes one at a time, zero past the last byte, then four chars
                     if (ld_ff != 2'd3 && ph_ff == 2'd0) begin
                        put = 1'b0;
                     end else begin
                        put = 1'b1;
                        case (ph_ff)
                           2'd0: ch = b64_char(grp_ff[23:18]);
                           2'd1: ch = b64_char(grp_ff[17:12]);
                           2'd2: ch = (9'(n_ff) - idx_ff > 9'd1) ?
                                      b64_char(grp_ff[11:6]) : 8'd61;
                           default: ch = (9'(n_ff) - idx_ff > 9'd2) ?
                                      b64_char(grp_ff[5:0]) : 8'd61;
                        endcase
                     end
                  end
                  SEG_TAIL: begin
                     put = 1'b1; ch = tail_char(idx_ff[4:0]);
                  end
                  default: put = 1'b0;
               endcase

               // base64 byte loader through the registered read port
               if (seg_ff == SEG_B64 && ph_ff == 2'd0 && ld_ff != 2'd3) begin
                  if (bi_ff != CW'(idx_ff) + CW'(ld_ff) + CW'(1) || ld_ff == 2'd0) begin
                     if (bi_ff == CW'(idx_ff) + CW'(ld_ff)) bi_in = bi_ff + CW'(1);
                  end
                  if (bi_ff == CW'(idx_ff) + CW'(ld_ff) + CW'(1)) begin
                     grp_in = grp_ff | ((9'(n_ff) > idx_ff + 9'(ld_ff)) ?
                              (24'(rd_ff) << (5'd16 - 5'(8 * ld_ff))) : 24'd0);
                     ld_in  = ld_ff + 2'd1;
                  end
               end

               if (put && out_free) begin
                  acc_in  = acc_ff | (64'(ch) << {accn_ff[2:0], 3'b000});
                  accn_in = accn_ff + 4'd1;
                  pos_in  = pos_ff + 9'd1;
                  // advance within segment
                  case (seg_ff)
                     SEG_HEAD: if (idx_ff == 9'(HEAD_LEN - 1)) begin
                        seg_in = SEG_CH; idx_in = 9'd0; end
                        else idx_in = idx_ff + 9'd1;
                     SEG_CH: if (d_cnt == 5'd1) begin
                        seg_in = SEG_TS; idx_in = 9'd0; end
                     SEG_TS: if (idx_ff == 9'(TS_LEN - 1)) begin
                        seg_in = SEG_TS_D; idx_in = 9'd0; d_start = 1'b1; end
                        else idx_in = idx_ff + 9'd1;
                     SEG_TS_D: if (d_cnt == 5'd1) begin
                        seg_in = SEG_DATA; idx_in = 9'd0; end
                     SEG_DATA: if (idx_ff == 9'(DATA_LEN - 1)) begin
                        seg_in = (n_ff == '0) ? SEG_TAIL : SEG_B64;
                        idx_in = 9'd0; ph_in = 2'd0; ld_in = 2'd0;
                        grp_in = 24'd0; bi_in = '0; end
                        else idx_in = idx_ff + 9'd1;
                     SEG_B64: begin
                        ph_in = ph_ff + 2'd1;
                        if (ph_ff == 2'd3) begin
                           ld_in = 2'd0; grp_in = 24'd0;
                           idx_in = idx_ff + 9'd3;
                           if (idx_ff + 9'd3 >= 9'(n_ff)) begin
                              seg_in = SEG_TAIL; idx_in = 9'd0; end
                        end
                     end
                     SEG_TAIL: if (idx_ff == 9'(TAIL_LEN - 1)) seg_in = SEG_DONE;
                        else idx_in = idx_ff + 9'd1;
                     default: seg_in = SEG_DONE;
                  endcase
                  // word full or line complete: hand to output register
                  if (accn_ff == 4'd7 || pos_ff + 9'd1 == len_ff) begin
                     ov_in             = 1'b1;
                     out_in.text_chars = acc_in;
                     out_in.char_count = accn_in;
                     out_in.status     = STATUS_OK;
                     out_in.line_length = len_ff;
                     out_in.last_word  = (pos_ff + 9'd1 == len_ff);
                     acc_in  = 64'd0;
                     accn_in = 4'd0;
                     if (pos_ff + 9'd1 == len_ff) state_in = ST_FLUSH;
                  end
               end
            end
         end
         ST_FLUSH: begin
            if (out_free) state_in = ST_COLLECT;
         end
         ST_ERR: begin
            if (out_free) begin
               ov_in              = 1'b1;
               out_in.text_chars  = 64'd0;
               out_in.char_count  = 4'd0;
               out_in.status      = err_ff;
               out_in.line_length = 9'd0;
               out_in.last_word   = 1'b1;
               state_in           = ST_COLLECT;
            end
         end
         default: state_in = ST_COLLECT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         ov_ff    <= ov_in;
      end
      seg_ff  <= seg_in;
      idx_ff  <= idx_in;
      ph_ff   <= ph_in;
      grp_ff  <= grp_in;
      ld_ff   <= ld_in;
      acc_ff  <= acc_in;
      accn_ff <= accn_in;
      pos_ff  <= pos_in;
      bi_ff   <= bi_in;
      out_ff  <= out_in;
      // capture event fields and byte count on the last item
      if (accept && req_last_byte) begin
         ch_ff  <= req_channel;
         ts_ff  <= req_event_time;
         n_ff   <= (count_ff < CW'(MAX_DATA_BYTES)) ? count_ff + CW'(1) : count_ff;
         err_ff <= STATUS_OVF;
      end
      // digit counts are known once each conversion ends
      if (state_ff == ST_DCH2 && !d_busy) chn_ff <= d_cnt;
      if (state_ff == ST_DTS && !d_busy) tsn_ff <= d_cnt;
      if (state_ff == ST_CHECK) begin
         len_ff <= len_calc;
         err_ff <= STATUS_NOSPC;
      end
   end

   assign rsp_valid       = ov_ff;
   assign rsp_text_chars  = out_ff.text_chars;
   assign rsp_char_count  = out_ff.char_count;
   assign rsp_status      = out_ff.status;
   assign rsp_line_length = out_ff.line_length;
   assign rsp_last_word   = out_ff.last_word;

`ifndef ASSERT_OFF
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_COLLECT) |-> req_stall)
      else $error("input accepted while busy");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_OK) |-> (rsp_char_count == 4'd0 && rsp_last_word))
      else $error("error word malformed");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_DATA_BYTES))
      else $error("byte count past maximum");
`endif
endmodule
`default_nettype wire
